@@ sv/fmwt_pkg.sv @@
// Shared definitions for the FM warble-tone generator: defaults, register codes,
// the controller command bundle and the quarter-wave sine entry function.
// No dependencies.
package fmwt_pkg;

    // Default sizes handed to the top level.
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Fixed register and bus widths.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 32;
    localparam int DEPTH_W    = 24;
    localparam int AMP_W      = 16;
    localparam int IN_TDATA_W = 8;

    // pi/2 in Q2.30, used to build the sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;

    typedef logic [63:0]        u64_t;
    typedef logic signed [63:0] s64_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CARRIER_STEP = 2'd0,
        REG_MOD_STEP     = 2'd1,
        REG_MOD_DEPTH    = 2'd2,
        REG_AMPLITUDE    = 2'd3
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // request accepted this cycle
        logic rom_read;  // load the sine table output register
        logic car_sel;   // table address comes from the deviated carrier phase
        logic dev_mul;   // register depth times modulator sine
        logic finish;    // register the sample and advance both phases
    } fmwt_cmd_t;

    // Quarter-wave sine entry k, scaled to full scale 2^(sample_bits-1)-1.
    // Evaluated at elaboration only, by an eight-term Taylor series in Q30.
    function automatic u64_t rom_entry(u64_t k, int t_bits, int sample_bits);
        u64_t x;
        u64_t x2;
        u64_t t;
        u64_t fs;
        s64_t s;
        x  = (k * HALF_PI_Q30) >> t_bits;
        x2 = (x * x) >> 30;
        t  = x;
        s  = s64_t'(x);
        t = ((t * x2) >> 30) / 64'd6;
        s = s - s64_t'(t);
        t = ((t * x2) >> 30) / 64'd20;
        s = s + s64_t'(t);
        t = ((t * x2) >> 30) / 64'd42;
        s = s - s64_t'(t);
        t = ((t * x2) >> 30) / 64'd72;
        s = s + s64_t'(t);
        t = ((t * x2) >> 30) / 64'd110;
        s = s - s64_t'(t);
        t = ((t * x2) >> 30) / 64'd156;
        s = s + s64_t'(t);
        t = ((t * x2) >> 30) / 64'd210;
        s = s - s64_t'(t);
        fs = (64'd1 << (sample_bits - 1)) - 64'd1;
        if (s < 0) begin
            s = 0;
        end
        s = s64_t'((u64_t'(s) * fs + (64'd1 << 29)) >> 30);
        if (s > s64_t'(fs)) begin
            s = s64_t'(fs);
        end
        return u64_t'(s);
    endfunction

endpackage

@@ sv/fmwt_ctrl.sv @@
// Sequencing controller of the FM warble-tone generator.
// Depends on fmwt_pkg for the command bundle.
module fmwt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output fmwt_pkg::fmwt_cmd_t cmd
);
    import fmwt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MOD_READ = 5'b00010,
        S_DEV_MUL  = 5'b00100,
        S_CAR_READ = 5'b01000,
        S_FINISH   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register may be refilled once it is empty or being taken.
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // Command decode and next state.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_MOD_READ;
                end
            end
            S_MOD_READ: begin
                cmd.rom_read = 1'b1;
                state_next   = S_DEV_MUL;
            end
            S_DEV_MUL: begin
                cmd.dev_mul = 1'b1;
                state_next  = S_CAR_READ;
            end
            S_CAR_READ: begin
                cmd.rom_read = 1'b1;
                cmd.car_sel  = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set when a sample lands, cleared when it is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/fmwt_datapath.sv @@
// Datapath of the FM warble-tone generator: registers, phase accumulators,
// quarter-wave sine table, deviation and gain multipliers. Depends on fmwt_pkg.
module fmwt_datapath #(
    parameter int PHASE_BITS      = fmwt_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = fmwt_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = fmwt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fmwt_pkg::fmwt_cmd_t             cmd,
    input  logic                            restart_phase,
    input  logic                            cfg_wr_en,
    input  logic [fmwt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [fmwt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output logic [SAMPLE_BITS-1:0]          sample
);
    import fmwt_pkg::*;

    localparam int N       = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int IDX_W   = SINE_TABLE_BITS + 2;
    localparam int MAG_W   = SAMPLE_BITS - 1;
    localparam int DPROD_W = DEPTH_W + 1 + SAMPLE_BITS;
    localparam int APROD_W = AMP_W + 1 + SAMPLE_BITS;
    localparam int E       = PHASE_BITS - 16 - (SAMPLE_BITS - 1);
    localparam int SHL     = (E >= 0) ? E : 0;
    localparam int SHR     = (E < 0) ? -E : 0;
    localparam int EXT_W   = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    typedef logic [MAG_W-1:0] rom_t [0:N];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= N; k++) begin
            r[k] = MAG_W'(rom_entry(u64_t'(k), SINE_TABLE_BITS, SAMPLE_BITS));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [STEP_W-1:0]         carrier_step_reg;
    logic [STEP_W-1:0]         mod_step_reg;
    logic [DEPTH_W-1:0]        mod_depth_reg;
    logic [AMP_W-1:0]          amplitude_reg;
    logic [PHASE_BITS-1:0]     car_phase_reg;
    logic [PHASE_BITS-1:0]     mod_phase_reg;
    logic [MAG_W-1:0]          rom_q_reg;
    logic                      neg_reg;
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [DPROD_W-1:0] dprod_next;
    logic [SAMPLE_BITS-1:0]    sample_reg;
    logic [SAMPLE_BITS-1:0]    sample_next;

    logic [EXT_W-1:0]              car_step_ext;
    logic [EXT_W-1:0]              mod_step_ext;
    s64_t                          dev_ext;
    s64_t                          dev_shift;
    logic [PHASE_BITS-1:0]         dev;
    logic [PHASE_BITS-1:0]         rd_phase;
    logic [IDX_W-1:0]              idx;
    logic [1:0]                    quad;
    logic [SINE_TABLE_BITS-1:0]    k_idx;
    logic [ADDR_W-1:0]             rom_addr;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [APROD_W-1:0]     aprod;

    // Steps wrap modulo one turn of the accumulator.
    assign car_step_ext = EXT_W'(carrier_step_reg);
    assign mod_step_ext = EXT_W'(mod_step_reg);

    // Phase deviation: scale the registered product to phase units, floor rounding.
    assign dev_ext   = s64_t'(dprod_reg);
    assign dev_shift = (dev_ext <<< SHL) >>> SHR;
    assign dev       = dev_shift[PHASE_BITS-1:0];

    // Table address: quadrant folding of the top phase bits.
    assign rd_phase = cmd.car_sel ? (car_phase_reg + dev) : mod_phase_reg;
    assign idx      = rd_phase[PHASE_BITS-1 -: IDX_W];
    assign quad     = idx[IDX_W-1 -: 2];
    assign k_idx    = idx[SINE_TABLE_BITS-1:0];
    assign rom_addr = quad[0] ? (ADDR_W'(N) - {1'b0, k_idx}) : {1'b0, k_idx};

    // Signed sine from the registered table word and the lower half-wave flag.
    assign sine_val = neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

    // Multipliers: depth times modulator sine, gain times carrier sine.
    assign dprod_next  = $signed({1'b0, mod_depth_reg}) * sine_val;
    assign aprod       = $signed({1'b0, amplitude_reg}) * sine_val;
    assign sample_next = aprod[16 +: SAMPLE_BITS];

    assign sample = sample_reg;

    // Sine table read, registered.
    always_ff @(posedge aclk) begin
        if (cmd.rom_read) begin
            rom_q_reg <= SINE_ROM[rom_addr];
            neg_reg   <= quad[1];
        end
    end

    // Product and output sample registers.
    always_ff @(posedge aclk) begin
        if (cmd.dev_mul) begin
            dprod_reg <= dprod_next;
        end
        if (cmd.finish) begin
            sample_reg <= sample_next;
        end
    end

    // Configuration registers and phase accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_step_reg <= '0;
            mod_step_reg     <= '0;
            mod_depth_reg    <= '0;
            amplitude_reg    <= '0;
            car_phase_reg    <= '0;
            mod_phase_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_CARRIER_STEP: carrier_step_reg <= cfg_wr_data[STEP_W-1:0];
                REG_MOD_STEP:     mod_step_reg     <= cfg_wr_data[STEP_W-1:0];
                REG_MOD_DEPTH:    mod_depth_reg    <= cfg_wr_data[DEPTH_W-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_wr_data[AMP_W-1:0];
            endcase
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
        end else if (cmd.start && restart_phase) begin
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
        end else if (cmd.finish) begin
            car_phase_reg <= car_phase_reg + car_step_ext[PHASE_BITS-1:0];
            mod_phase_reg <= mod_phase_reg + mod_step_ext[PHASE_BITS-1:0];
        end
    end

endmodule

@@ sv/fm_warble_tone_generator.sv @@
// Top level of the FM warble-tone generator: controller plus datapath.
// Depends on fmwt_pkg, fmwt_ctrl and fmwt_datapath.
//
//   Channel   Direction  Contents
//   s_*       in         one sample tick per request, tdata[0] = restart_phase
//   m_*       out        one signed sample per request, tdata[SAMPLE_BITS-1:0]
//   cfg_wr_*  in         register writes, index 0..3, no read-back
//
// After acceptance a request steps through S_MOD_READ, S_DEV_MUL, S_CAR_READ and
// S_FINISH, where its sample lands: one table read and one multiply for the modulator,
// then the same for the carrier, all through a single registered sine table port.
// A new request is taken in the cycle after the sample lands, even while that sample is still waiting.
// A stalled output holds the final step until the sample register frees up.
// Reset is synchronous and clears the controller, the configuration registers and both phases.
module fm_warble_tone_generator #(
    parameter int PHASE_BITS      = fmwt_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = fmwt_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = fmwt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: restart_phase, then zero fill.
    input  logic [fmwt_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: sample, then zero fill.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [fmwt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [fmwt_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import fmwt_pkg::*;

    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    fmwt_cmd_t              cmd;
    logic [SAMPLE_BITS-1:0] sample;

    fmwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fmwt_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .restart_phase (s_tdata[0]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .sample        (sample)
    );

    // Zero-fill the sample up to whole bytes.
    assign m_tdata = OUT_TDATA_W'(sample);

endmodule
